// ----- src/u8d_pkg.sv -----
package u8d_pkg;

    localparam int unsigned CpWidth = 31;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_BAD_LEAD = 2'd1;
    localparam t_status ST_TRUNC    = 2'd2;

    typedef struct packed {
        logic [CpWidth-1:0] code_point;
        t_status            status;
    } t_result;

    // payload masks of the lead byte classes and of continuation bytes
    localparam logic [7:0] MASK_2B = 8'h1F;
    localparam logic [7:0] MASK_3B = 8'h0F;
    localparam logic [7:0] MASK_4B = 8'h07;
    localparam logic [7:0] MASK_5B = 8'h03;
    localparam logic [7:0] MASK_6B = 8'h01;
    localparam logic [7:0] MASK_CONT = 8'h3F;

    // lead byte prefixes, compared against the byte shifted right
    localparam logic [2:0] PFX_2B = 3'h6;
    localparam logic [3:0] PFX_3B = 4'hE;
    localparam logic [4:0] PFX_4B = 5'h1E;
    localparam logic [5:0] PFX_5B = 6'h3E;
    localparam logic [6:0] PFX_6B = 7'h7E;

endpackage

// ----- src/u8d_if.sv -----
interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface u8d_cp_if;
    logic                         valid;
    logic                         ready;
    logic [u8d_pkg::CpWidth-1:0]  code_point;
    u8d_pkg::t_status             status;

    modport source (output valid, output code_point, output status, input ready);
    modport sink   (input valid, input code_point, input status, output ready);
endinterface

// ----- src/u8d_core.sv -----
module u8d_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    u8d_byte_if.sink          i_byte,
    output logic              o_res_valid,
    output u8d_pkg::t_result  o_res,
    input  logic              i_res_ready
);

    logic                        r_in_valid;
    logic [7:0]                  r_byte;
    logic                        r_eot;
    logic [2:0]                  r_remaining;
    logic [u8d_pkg::CpWidth-1:0] r_accum;

    logic [2:0]                  n_remaining;
    logic [u8d_pkg::CpWidth-1:0] n_accum;
    logic                        produce;
    logic                        advance;
    logic                        lead_ok;
    logic [2:0]                  lead_need;
    logic [7:0]                  lead_payload;
    logic [u8d_pkg::CpWidth-1:0] shifted;
    logic [2:0]                  rem_dec;
    u8d_pkg::t_result            res;

    assign advance      = r_in_valid && (!produce || i_res_ready);
    assign i_byte.ready = !r_in_valid || advance;
    assign o_res_valid  = r_in_valid && produce;
    assign o_res        = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_byte <= i_byte.data_byte;
            r_eot  <= i_byte.end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= 3'd0;
            r_accum     <= '0;
        end else if (advance) begin
            r_remaining <= n_remaining;
            r_accum     <= n_accum;
        end
    end

    // classify the lead byte
    always_comb begin
        lead_ok      = 1'b1;
        lead_need    = 3'd0;
        lead_payload = 8'd0;
        priority if (r_byte[7:5] == u8d_pkg::PFX_2B) begin
            lead_need    = 3'd1;
            lead_payload = r_byte & u8d_pkg::MASK_2B;
        end else if (r_byte[7:4] == u8d_pkg::PFX_3B) begin
            lead_need    = 3'd2;
            lead_payload = r_byte & u8d_pkg::MASK_3B;
        end else if (r_byte[7:3] == u8d_pkg::PFX_4B) begin
            lead_need    = 3'd3;
            lead_payload = r_byte & u8d_pkg::MASK_4B;
        end else if (r_byte[7:2] == u8d_pkg::PFX_5B) begin
            lead_need    = 3'd4;
            lead_payload = r_byte & u8d_pkg::MASK_5B;
        end else if (r_byte[7:1] == u8d_pkg::PFX_6B) begin
            lead_need    = 3'd5;
            lead_payload = r_byte & u8d_pkg::MASK_6B;
        end else begin
            lead_ok = 1'b0;
        end
    end

    assign shifted = {r_accum[u8d_pkg::CpWidth-7:0], r_byte[5:0] & u8d_pkg::MASK_CONT[5:0]};
    assign rem_dec = r_remaining - 3'd1;

    always_comb begin
        n_remaining    = r_remaining;
        n_accum        = r_accum;
        produce        = 1'b0;
        res.code_point = '0;
        res.status     = u8d_pkg::ST_OK;
        if (r_remaining == 3'd0) begin
            if (!r_byte[7]) begin
                produce        = 1'b1;
                res.code_point = {{(u8d_pkg::CpWidth-8){1'b0}}, r_byte};
            end else if (!lead_ok) begin
                produce        = 1'b1;
                res.code_point = {{(u8d_pkg::CpWidth-8){1'b0}}, r_byte};
                res.status     = u8d_pkg::ST_BAD_LEAD;
            end else if (r_eot) begin
                produce     = 1'b1;
                res.status  = u8d_pkg::ST_TRUNC;
                n_remaining = 3'd0;
                n_accum     = '0;
            end else begin
                n_remaining = lead_need;
                n_accum     = {{(u8d_pkg::CpWidth-8){1'b0}}, lead_payload};
            end
        end else begin
            if (rem_dec == 3'd0) begin
                produce        = 1'b1;
                res.code_point = shifted;
                n_remaining    = 3'd0;
                n_accum        = '0;
            end else if (r_eot) begin
                // end of text inside a sequence: drop the partial code point
                produce     = 1'b1;
                res.status  = u8d_pkg::ST_TRUNC;
                n_remaining = 3'd0;
                n_accum     = '0;
            end else begin
                n_remaining = rem_dec;
                n_accum     = shifted;
            end
        end
    end

    a_remaining_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remaining <= 3'd5)
        else $error("continuation count out of range");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("stalled result changed");

    a_bad_lead_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.status == u8d_pkg::ST_BAD_LEAD |-> r_remaining == 3'd0)
        else $error("bad lead reported inside a sequence");

    a_complete_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && produce && r_remaining != 3'd0 |=> r_remaining == 3'd0 && r_accum == '0)
        else $error("state not cleared after sequence end");

endmodule

// ----- src/u8d_out_reg.sv -----
module u8d_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  u8d_pkg::t_result  i_res,
    output logic              o_res_ready,
    u8d_cp_if.source          o_cp
);

    logic             r_valid;
    u8d_pkg::t_result r_res;

    assign o_res_ready   = !r_valid || o_cp.ready;
    assign o_cp.valid      = r_valid;
    assign o_cp.code_point = r_res.code_point;
    assign o_cp.status     = r_res.status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid && o_res_ready) begin
            r_valid <= 1'b1;
        end else if (o_cp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid && o_res_ready) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- src/utf8_stream_decoder_unit.sv -----
// The input register and the result register lie between a byte's acceptance and its result.
// Throughput: one byte per cycle; the input register and the result register
// hold the pipeline together under backpressure from either side.
// A byte that ends no sequence gives no result unless it is a bad lead or carries end of text.
// Reset (synchronous, active low) empties both registers and returns to awaiting a lead byte.
module utf8_stream_decoder_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    u8d_byte_if.sink  i_byte,
    u8d_cp_if.source  o_cp
);

    logic             res_valid;
    logic             res_ready;
    u8d_pkg::t_result res;

    u8d_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    u8d_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_cp        (o_cp)
    );

endmodule

// ----- tb/utf8_stream_decoder_unit_test.sv -----
`timescale 1ns / 100ps

module utf8_stream_decoder_unit_test;

    localparam int HalfPeriod  = 6;
    localparam int QuietLimit  = 1000;
    localparam int DrainCycles = 12;
    localparam int CpWidth     = u8d_pkg::CpWidth;

    logic clk;
    logic rst_n;

    u8d_byte_if byte_ch ();
    u8d_cp_if   cp_ch ();

    utf8_stream_decoder_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_ch.sink),
        .o_cp    (cp_ch.source)
    );

    // decoder state as predicted from the accepted bytes
    logic [2:0]         cont_left;
    logic [CpWidth-1:0] cp_accum;

    u8d_pkg::t_result expected_cps[$];
    int               error_count;
    int               bytes_sent;
    int               quiet_cycles;
    bit               gaps_on;

    always #(HalfPeriod) clk = ~clk;

    function automatic void decode_byte(input logic [7:0] b, input logic eot,
                                        output logic emitted, output u8d_pkg::t_result res);
        logic [2:0]         need;
        logic [CpWidth-1:0] payload;
        emitted = 1'b0;
        res     = '0;
        need    = '0;
        payload = '0;
        if (cont_left == 3'd0) begin
            if (b[7] == 1'b0) begin
                emitted = 1'b1;
                res     = '{code_point: CpWidth'(b), status: u8d_pkg::ST_OK};
            end else if (b[7:5] == u8d_pkg::PFX_2B) begin
                need    = 3'd1;
                payload = CpWidth'(b & u8d_pkg::MASK_2B);
            end else if (b[7:4] == u8d_pkg::PFX_3B) begin
                need    = 3'd2;
                payload = CpWidth'(b & u8d_pkg::MASK_3B);
            end else if (b[7:3] == u8d_pkg::PFX_4B) begin
                need    = 3'd3;
                payload = CpWidth'(b & u8d_pkg::MASK_4B);
            end else if (b[7:2] == u8d_pkg::PFX_5B) begin
                need    = 3'd4;
                payload = CpWidth'(b & u8d_pkg::MASK_5B);
            end else if (b[7:1] == u8d_pkg::PFX_6B) begin
                need    = 3'd5;
                payload = CpWidth'(b & u8d_pkg::MASK_6B);
            end else begin
                emitted = 1'b1;
                res     = '{code_point: CpWidth'(b), status: u8d_pkg::ST_BAD_LEAD};
            end
            if (need != 3'd0) begin
                if (eot) begin
                    cont_left = '0;
                    cp_accum  = '0;
                    emitted   = 1'b1;
                    res       = '{code_point: '0, status: u8d_pkg::ST_TRUNC};
                end else begin
                    cont_left = need;
                    cp_accum  = payload;
                end
            end
        end else begin
            // any byte counts as a continuation here, only its low six bits matter
            cp_accum  = {cp_accum[CpWidth-7:0], b[5:0]};
            cont_left = cont_left - 3'd1;
            if (cont_left == 3'd0) begin
                emitted  = 1'b1;
                res      = '{code_point: cp_accum, status: u8d_pkg::ST_OK};
                cp_accum = '0;
            end else if (eot) begin
                cont_left = '0;
                cp_accum  = '0;
                emitted   = 1'b1;
                res       = '{code_point: '0, status: u8d_pkg::ST_TRUNC};
            end
        end
    endfunction

    // enter and leave at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eot);
        logic             emitted;
        u8d_pkg::t_result res;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= b;
        byte_ch.end_of_text <= eot;
        do @(posedge clk); while (!byte_ch.ready);
        decode_byte(b, eot, emitted, res);
        if (emitted) expected_cps.insert(expected_cps.size(), res);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic test_ascii_extremes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_lead_classes();
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'h88, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        // six-byte form with non-continuation bytes in the tail: largest code point
        send_byte(8'hFD, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h3F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h7F, 1'b0);
    endtask

    task automatic test_invalid_leads();
        send_byte(8'h80, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_truncation();
        send_byte(8'hC2, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
    endtask

    task automatic send_random_sequence();
        int         len;
        int         cut;
        logic [7:0] b;
        logic       eot;
        if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 3))
                0: b = {2'b10, 6'($urandom)};
                1: b = 8'hFE;
                2: b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            send_byte(b, $urandom_range(0, 7) == 0);
            return;
        end
        len = $urandom_range(1, 6);
        cut = -1;
        if (len > 1 && $urandom_range(0, 7) == 0) cut = $urandom_range(0, len - 2);
        for (int i = 0; i < len; i++) begin
            if (i == 0) begin
                case (len)
                    1: b = {1'b0, 7'($urandom)};
                    2: b = {u8d_pkg::PFX_2B, 5'($urandom)};
                    3: b = {u8d_pkg::PFX_3B, 4'($urandom)};
                    4: b = {u8d_pkg::PFX_4B, 3'($urandom)};
                    5: b = {u8d_pkg::PFX_5B, 2'($urandom)};
                    default: b = {u8d_pkg::PFX_6B, 1'($urandom)};
                endcase
            end else if ($urandom_range(0, 99) < 15) begin
                b = 8'($urandom);
            end else begin
                b = {2'b10, 6'($urandom)};
            end
            eot = (i == cut) || (i == len - 1 && $urandom_range(0, 9) == 0);
            send_byte(b, eot);
            if (i == cut) break;
        end
    endtask

    task automatic test_random_with_gaps();
        while (bytes_sent < 520) send_random_sequence();
    endtask

    task automatic test_steady_stream();
        gaps_on = 1'b0;
        while (bytes_sent < 650) send_random_sequence();
    endtask

    // result side: random stall bursts while gaps are on
    initial begin
        cp_ch.ready = 1'b1;
        forever begin
            @(negedge clk);
            if (gaps_on && $urandom_range(0, 7) == 0) begin
                cp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            cp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        u8d_pkg::t_result want;
        if (rst_n && cp_ch.valid && cp_ch.ready) begin
            if (expected_cps.size() == 0) begin
                $display("%0t unexpected transaction: code_point %h status %0d", $time,
                         cp_ch.code_point, cp_ch.status);
                error_count++;
            end else begin
                want = expected_cps.pop_front();
                if (cp_ch.code_point !== want.code_point) begin
                    $display("%0t code_point mismatch: expected %h actual %h", $time,
                             want.code_point, cp_ch.code_point);
                    error_count++;
                end
                if (cp_ch.status !== want.status) begin
                    $display("%0t status mismatch: expected %0d actual %0d", $time,
                             want.status, cp_ch.status);
                    error_count++;
                end
            end
        end
    end

    // abort when neither side moves a transaction for too long
    always @(posedge clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (cp_ch.valid && cp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("timeout after %0d idle cycles, %0d results pending", quiet_cycles,
                     expected_cps.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = '0;
        byte_ch.end_of_text = 1'b0;
        cont_left           = '0;
        cp_accum            = '0;
        error_count         = 0;
        bytes_sent          = 0;
        quiet_cycles        = 0;
        gaps_on             = 1'b1;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_ascii_extremes();
        test_lead_classes();
        test_invalid_leads();
        test_truncation();
        test_random_with_gaps();
        test_steady_stream();

        byte_ch.valid <= 1'b0;
        while (expected_cps.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/u8d_pkg.sv
src/u8d_if.sv
src/u8d_core.sv
src/u8d_out_reg.sv
src/utf8_stream_decoder_unit.sv
tb/utf8_stream_decoder_unit_test.sv
